[src/bsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

	// Signed ordering codes on newer_order
	localparam logic signed [1:0] ORDER_EQUAL   = 2'sb00;
	localparam logic signed [1:0] ORDER_A_NEWER = 2'sb01;
	localparam logic signed [1:0] ORDER_B_NEWER = 2'sb11;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [15:0] YEAR_MIN_BCD = 16'h1970;
	localparam logic [6:0]  DAY_MAX      = 7'd31;
	localparam logic [6:0]  HOUR_MAX     = 7'd23;
	localparam logic [3:0]  TENS_MAX_MS  = 4'd5;

	// Date key: year as BCD, month 1..12, day 1..31; sorts in calendar order
	typedef struct packed {
		logic        ok;
		logic [24:0] key;
	} date_t;

	// Time key: hh mm ss as BCD; sorts in time order once validated
	typedef struct packed {
		logic        ok;
		logic [23:0] key;
	} clock_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic [3:0] month_num(input logic [23:0] name);
		logic [3:0] m;
		unique case (name)
			"Jan":   m = 4'd1;
			"Feb":   m = 4'd2;
			"Mar":   m = 4'd3;
			"Apr":   m = 4'd4;
			"May":   m = 4'd5;
			"Jun":   m = 4'd6;
			"Jul":   m = 4'd7;
			"Aug":   m = 4'd8;
			"Sep":   m = 4'd9;
			"Oct":   m = 4'd10;
			"Nov":   m = 4'd11;
			"Dec":   m = 4'd12;
			default: m = 4'd0;
		endcase
		return m;
	endfunction

	function automatic date_t date_parse(input logic [63:0] head, input logic [23:0] tail);
		date_t      d;
		logic [3:0] mon;
		logic [3:0] tens;
		logic [6:0] day;
		logic       day_ok;
		logic       year_ok;
		logic [15:0] year;
		mon  = month_num(head[63:40]);
		// A leading space on the day counts as a zero tens digit
		tens = (head[31:24] == CHAR_SPACE) ? 4'd0 : head[27:24];
		day  = 7'(tens) * 7'd10 + 7'(head[19:16]);
		day_ok = is_digit(head[23:16]) &&
			((head[31:24] == CHAR_SPACE) || is_digit(head[31:24])) &&
			(day != 7'd0) && (day <= DAY_MAX);
		year    = {head[3:0], tail[19:16], tail[11:8], tail[3:0]};
		year_ok = is_digit(head[7:0]) && is_digit(tail[23:16]) &&
			is_digit(tail[15:8]) && is_digit(tail[7:0]) && (year >= YEAR_MIN_BCD);
		d.ok  = (mon != 4'd0) && (head[39:32] == CHAR_SPACE) &&
			(head[15:8] == CHAR_SPACE) && day_ok && year_ok;
		d.key = {year, mon, day[4:0]};
		return d;
	endfunction

	function automatic clock_t clock_parse(input logic [63:0] text);
		clock_t     t;
		logic [6:0] hour;
		logic       chars_ok;
		chars_ok = is_digit(text[63:56]) && is_digit(text[55:48]) &&
			(text[47:40] == CHAR_COLON) && is_digit(text[39:32]) &&
			is_digit(text[31:24]) && (text[23:16] == CHAR_COLON) &&
			is_digit(text[15:8]) && is_digit(text[7:0]);
		hour  = 7'(text[59:56]) * 7'd10 + 7'(text[51:48]);
		t.ok  = chars_ok && (hour <= HOUR_MAX) &&
			(text[35:32] <= TENS_MAX_MS) && (text[11:8] <= TENS_MAX_MS);
		t.key = {text[59:56], text[51:48], text[35:32], text[27:24],
			text[11:8], text[3:0]};
		return t;
	endfunction

endpackage

`default_nettype wire

[src/build_stamp_compare_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Build stamp comparator.
// Command channel: raise start with both stamps (date head/tail and clock
// text, ASCII, first character in the top byte) on the input ports; the
// beat is taken at the rising edge where start is high and busy is low.
// busy is always low, so a new beat may be issued in every cycle.
// Result channel: done pulses for one cycle with newer_order on the ports:
// +1 when stamp A is newer, -1 when stamp B is newer, 0 when equal or
// when a needed field fails to parse (times count only on equal dates).
// A taken beat passes the input register, then the result register,
// before done shows its result. Throughput: one beat per cycle, set by
// the input register and the result register around a single parse and
// compare stage.
// Reset: arst_n clears the valid flags at once; no stale result appears.
// The receiver cannot stall: each result is shown for exactly one cycle
// and must be taken then.

module build_stamp_compare_unit
	import bsc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [63:0]        a_date_head,
	input  wire logic [23:0]        a_date_tail,
	input  wire logic [63:0]        a_clock_text,
	input  wire logic [63:0]        b_date_head,
	input  wire logic [23:0]        b_date_tail,
	input  wire logic [63:0]        b_clock_text,
	output logic                    done,
	output logic signed [1:0]       newer_order
);

	// Input register stage
	logic        valid_s1;
	logic [63:0] a_date_head_s1;
	logic [23:0] a_date_tail_s1;
	logic [63:0] a_clock_text_s1;
	logic [63:0] b_date_head_s1;
	logic [23:0] b_date_tail_s1;
	logic [63:0] b_clock_text_s1;

	// Result register stage
	logic              valid_s2;
	logic signed [1:0] order_s2;

	date_t             a_date;
	date_t             b_date;
	clock_t            a_clock;
	clock_t            b_clock;
	logic signed [1:0] order;

	// Never stall the command side: both stages advance every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// Payload: capture only on an accepted beat, hold otherwise
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			a_date_head_s1  <= a_date_head;
			a_date_tail_s1  <= a_date_tail;
			a_clock_text_s1 <= a_clock_text;
			b_date_head_s1  <= b_date_head;
			b_date_tail_s1  <= b_date_tail;
			b_clock_text_s1 <= b_clock_text;
		end
	end

	always_comb begin
		a_date  = date_parse(a_date_head_s1, a_date_tail_s1);
		b_date  = date_parse(b_date_head_s1, b_date_tail_s1);
		a_clock = clock_parse(a_clock_text_s1);
		b_clock = clock_parse(b_clock_text_s1);
	end

	// Dates decide first; the clock text only breaks a tie between valid dates
	always_comb begin
		priority if (!(a_date.ok && b_date.ok)) begin
			order = ORDER_EQUAL;
		end else if (a_date.key > b_date.key) begin
			order = ORDER_A_NEWER;
		end else if (a_date.key < b_date.key) begin
			order = ORDER_B_NEWER;
		end else if (!(a_clock.ok && b_clock.ok)) begin
			order = ORDER_EQUAL;
		end else if (a_clock.key > b_clock.key) begin
			order = ORDER_A_NEWER;
		end else if (a_clock.key < b_clock.key) begin
			order = ORDER_B_NEWER;
		end else begin
			order = ORDER_EQUAL;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			order_s2 <= order;
		end
	end

	assign done        = valid_s2;
	assign newer_order = order_s2;

endmodule

`default_nettype wire

[src/bsc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsc_checker
	import bsc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [63:0]       a_date_head,
	input wire logic [23:0]       a_date_tail,
	input wire logic [63:0]       a_clock_text,
	input wire logic [63:0]       b_date_head,
	input wire logic [23:0]       b_date_tail,
	input wire logic [63:0]       b_clock_text,
	input wire logic              done,
	input wire logic signed [1:0] newer_order
);

	// Every accepted beat yields a result through the input and result registers
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat produced no result");

	// No result without an earlier accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without an accepted beat");

	// Only the three ordering codes appear
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (newer_order == ORDER_EQUAL || newer_order == ORDER_A_NEWER ||
			newer_order == ORDER_B_NEWER))
		else $error("illegal ordering code");

	// Identical stamps never order one above the other
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(a_date_head == b_date_head && a_date_tail == b_date_tail &&
			a_clock_text == b_clock_text, 2)) |-> (newer_order == ORDER_EQUAL))
		else $error("identical stamps ordered as different");

endmodule

bind build_stamp_compare_unit bsc_checker u_bsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.a_date_head  (a_date_head),
	.a_date_tail  (a_date_tail),
	.a_clock_text (a_clock_text),
	.b_date_head  (b_date_head),
	.b_date_tail  (b_date_tail),
	.b_clock_text (b_clock_text),
	.done         (done),
	.newer_order  (newer_order)
);

`default_nettype wire
